FILE: design/caller_id_message_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Caller ID message parser assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CALLER_ID_MESSAGE_PARSER_TOP_MACROS_SVH
`define CALLER_ID_MESSAGE_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CIDP_ASSERT(label_, prop_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) else $error(msg_);
`define CIDP_ASSERT_NEVER(label_, expr_, msg_) \
  `CIDP_ASSERT(label_, !(expr_), msg_)
`else
`define CIDP_ASSERT(label_, prop_, msg_)
`define CIDP_ASSERT_NEVER(label_, expr_, msg_)
`endif

`endif

FILE: design/cidp_pkg.sv
// ----------------------------------------------------------------------------
// Caller ID message parser package
// Field widths, message and data type codes, byte role and record kind codes.
// ----------------------------------------------------------------------------
package cidp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROLE_W = 3;
  localparam int unsigned KIND_W = 3;

  localparam logic [BYTE_W-1:0] TYPE_MDMF    = 8'h80;
  localparam logic [BYTE_W-1:0] TYPE_SDMF    = 8'h04;
  localparam logic [BYTE_W-1:0] DT_DATE_TIME = 8'h01;
  localparam logic [BYTE_W-1:0] DT_NUMBER    = 8'h02;
  localparam logic [BYTE_W-1:0] DT_NO_NUMBER = 8'h04;
  localparam logic [BYTE_W-1:0] DT_NAME      = 8'h07;
  localparam logic [BYTE_W-1:0] DT_NO_NAME   = 8'h08;

  localparam logic [ROLE_W-1:0] ROLE_MSG_TYPE  = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_MSG_LEN   = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_DATA_TYPE = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_DATA_LEN  = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_DATA      = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_CHECKSUM  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_DATE_TIME = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NO_NUMBER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NAME      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_NAME   = 3'd4;

endpackage

FILE: design/cidp_if.sv
// ----------------------------------------------------------------------------
// Caller ID message parser channels
// Byte input channel and parsed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cidp_in_if
  import cidp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cidp_out_if
  import cidp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ROLE_W-1:0] byte_role;
  logic [KIND_W-1:0] record_kind;
  logic [BYTE_W-1:0] byte_value;
  logic              message_format;
  logic              message_done;
  logic              checksum_ok;
  logic              format_error;

  modport source (
    output valid, output byte_role, output record_kind, output byte_value,
    output message_format, output message_done, output checksum_ok,
    output format_error, input ready
  );
  modport sink (
    input valid, input byte_role, input record_kind, input byte_value,
    input message_format, input message_done, input checksum_ok,
    input format_error, output ready
  );
endinterface

FILE: design/caller_id_message_parser_top.sv
// Result path: an accepted byte passes through the input register, then the result register.
// Throughput: 1 byte per cycle while the result is not stalled; the frame state updates as a byte moves to the result.
// A stalled result holds the result register; the input register takes one more byte.
// Reset (rst_ni low, asynchronous): frame state to expect message type, both stages empty.
// ----------------------------------------------------------------------------
// Caller ID message parser
// Walks SDMF/MDMF frames byte by byte and reports role, record, checksum and format errors.
// ----------------------------------------------------------------------------
`include "caller_id_message_parser_top_macros.svh"

module caller_id_message_parser_top
  import cidp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cidp_in_if.sink    in_i,
  cidp_out_if.source out_o
);

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_DTYPE  = 3'd2,
    PH_DLEN   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  logic              item_vld_q;
  logic [BYTE_W-1:0] item_q;
  logic              out_vld_q;
  logic              advance;

  phase_e            phase_q, phase_d;
  logic              mdmf_q, mdmf_d;
  logic              name_q, name_d;
  logic              number_q, number_d;
  logic [BYTE_W-1:0] left_q, left_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] left_dec;
  logic [BYTE_W-1:0] sum_next;

  logic [ROLE_W-1:0] role_d, role_q;
  logic [KIND_W-1:0] rkind_d, rkind_q;
  logic [BYTE_W-1:0] value_q;
  logic              fmt_d, fmt_q;
  logic              done_d, done_q;
  logic              ok_d, ok_q;
  logic              err_d, err_q;
  logic              again;

  assign advance    = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;
  assign left_dec   = left_q - 8'd1;
  assign sum_next   = sum_q + item_q;

  always_comb begin
    phase_d  = phase_q;
    mdmf_d   = mdmf_q;
    name_d   = name_q;
    number_d = number_q;
    left_d   = left_q;
    kind_d   = kind_q;
    role_d   = ROLE_MSG_TYPE;
    rkind_d  = KIND_DATE_TIME;
    fmt_d    = mdmf_q;
    done_d   = 1'b0;
    ok_d     = 1'b0;
    err_d    = 1'b0;
    again    = 1'b0;
    unique case (phase_q)
      PH_LENGTH: begin
        role_d  = ROLE_MSG_LEN;
        phase_d = PH_DTYPE;
      end
      PH_DTYPE: begin
        role_d = ROLE_DATA_TYPE;
        unique case (item_q)
          DT_DATE_TIME: kind_d = KIND_DATE_TIME;
          DT_NUMBER: begin
            kind_d   = KIND_NUMBER;
            number_d = 1'b1;
          end
          DT_NO_NUMBER: begin
            kind_d   = KIND_NO_NUMBER;
            number_d = 1'b1;
          end
          DT_NAME: begin
            kind_d = KIND_NAME;
            name_d = 1'b1;
          end
          DT_NO_NAME: begin
            kind_d = KIND_NO_NAME;
            name_d = 1'b1;
          end
          default: err_d = 1'b1;
        endcase
        if (err_d) begin
          again = 1'b1;
        end else begin
          rkind_d = kind_d;
          phase_d = PH_DLEN;
        end
      end
      PH_DLEN: begin
        role_d  = ROLE_DATA_LEN;
        rkind_d = kind_q;
        if (item_q == '0) begin
          err_d = 1'b1;
          again = 1'b1;
        end else begin
          left_d  = item_q;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        role_d  = ROLE_DATA;
        rkind_d = kind_q;
        left_d  = left_dec;
        if (left_dec == '0) begin
          if ((mdmf_q && name_q && number_q) || (!mdmf_q && number_q)) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_DTYPE;
          end
        end
      end
      PH_CHECK: begin
        role_d = ROLE_CHECKSUM;
        done_d = 1'b1;
        ok_d   = (sum_next == '0);
        again  = 1'b1;
      end
      default: begin
        role_d = ROLE_MSG_TYPE;
        if (item_q == TYPE_MDMF) begin
          mdmf_d  = 1'b1;
          phase_d = PH_LENGTH;
        end else if (item_q == TYPE_SDMF) begin
          mdmf_d  = 1'b0;
          phase_d = PH_LENGTH;
        end else begin
          err_d = 1'b1;
          again = 1'b1;
        end
        fmt_d = err_d ? 1'b0 : mdmf_d;
      end
    endcase
    sum_d = sum_next;
    if (again) begin
      phase_d  = PH_TYPE;
      mdmf_d   = 1'b0;
      name_d   = 1'b0;
      number_d = 1'b0;
      left_d   = '0;
      kind_d   = KIND_DATE_TIME;
      sum_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      phase_q    <= PH_TYPE;
      mdmf_q     <= 1'b0;
      name_q     <= 1'b0;
      number_q   <= 1'b0;
      left_q     <= '0;
      kind_q     <= KIND_DATE_TIME;
      sum_q      <= '0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        phase_q   <= phase_d;
        mdmf_q    <= mdmf_d;
        name_q    <= name_d;
        number_q  <= number_d;
        left_q    <= left_d;
        kind_q    <= kind_d;
        sum_q     <= sum_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.rx_byte;
    end
    if (advance) begin
      role_q  <= role_d;
      rkind_q <= rkind_d;
      value_q <= item_q;
      fmt_q   <= fmt_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
      err_q   <= err_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.byte_role      = role_q;
  assign out_o.record_kind    = rkind_q;
  assign out_o.byte_value     = value_q;
  assign out_o.message_format = fmt_q;
  assign out_o.message_done   = done_q;
  assign out_o.checksum_ok    = ok_q;
  assign out_o.format_error   = err_q;

  `CIDP_ASSERT(a_done_on_checksum, out_vld_q && done_q |-> role_q == ROLE_CHECKSUM, "done off checksum byte")
  `CIDP_ASSERT_NEVER(a_ok_without_done, out_vld_q && ok_q && !done_q, "checksum ok without done")
  `CIDP_ASSERT(a_restart, advance && (done_d || err_d) |=> phase_q == PH_TYPE && sum_q == '0 && !name_q && !number_q, "no restart after frame end")
  `CIDP_ASSERT_NEVER(a_stall_empty, !in_i.ready && !item_vld_q, "stall with empty input register")
  `CIDP_ASSERT(a_left_in_data, item_vld_q && phase_q == PH_DATA |-> left_q != '0, "data phase with zero count")

endmodule
